// File: hw/rtl/imucf_pkg.sv
// Package: shared constants, types and the CORDIC arctangent table.
`default_nettype none
package imucf_pkg;
    localparam int CordicStepsDef = 16;
    localparam int AngleFracDef   = 16;
    localparam int ZW = 34;  // angle accumulator, 2^-24 deg
    localparam int XW = 44;  // CORDIC x/y datapath width
    localparam logic [2:0] AddrGain = 3'd0;
    localparam logic [2:0] AddrAlpha = 3'd1;
    localparam logic [2:0] AddrMlow = 3'd2;
    localparam logic [2:0] AddrMhigh = 3'd3;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_vec;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
        case (i)
            5'd0: atan_lut = 34'sd754974720;
            5'd1: atan_lut = 34'sd445687602;
            5'd2: atan_lut = 34'sd235489088;
            5'd3: atan_lut = 34'sd119537938;
            5'd4: atan_lut = 34'sd60000934;
            5'd5: atan_lut = 34'sd30029717;
            5'd6: atan_lut = 34'sd15018523;
            5'd7: atan_lut = 34'sd7509720;
            5'd8: atan_lut = 34'sd3754917;
            5'd9: atan_lut = 34'sd1877466;
            5'd10: atan_lut = 34'sd938734;
            5'd11: atan_lut = 34'sd469367;
            5'd12: atan_lut = 34'sd234684;
            5'd13: atan_lut = 34'sd117342;
            5'd14: atan_lut = 34'sd58671;
            5'd15: atan_lut = 34'sd29335;
            5'd16: atan_lut = 34'sd14668;
            5'd17: atan_lut = 34'sd7334;
            5'd18: atan_lut = 34'sd3667;
            5'd19: atan_lut = 34'sd1833;
            5'd20: atan_lut = 34'sd917;
            5'd21: atan_lut = 34'sd458;
            5'd22: atan_lut = 34'sd229;
            5'd23: atan_lut = 34'sd115;
            default: atan_lut = '0;
        endcase
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/imucf_cell.sv
// One CORDIC vectoring cell: a registered micro-rotation at a fixed shift.
`default_nettype none
module imucf_cell
    import imucf_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire       i_clk,
    input  wire t_vec i_vec,
    output t_vec      o_vec
);
    t_vec r_vec;
    t_vec n_vec;
    logic signed [XW-1:0] xs, ys;

    always_comb begin
        xs = i_vec.x >>> STEP;
        ys = i_vec.y >>> STEP;
        if (i_vec.y > 0) begin
            n_vec.x = i_vec.x + ys;
            n_vec.y = i_vec.y - xs;
            n_vec.z = i_vec.z + atan_lut(5'(STEP));
        end else begin
            n_vec.x = i_vec.x - ys;
            n_vec.y = i_vec.y + xs;
            n_vec.z = i_vec.z - atan_lut(5'(STEP));
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_vec = r_vec;
endmodule
`default_nettype wire

// File: hw/rtl/imucf_chain.sv
// Row of CORDIC cells with quadrant pre-rotation and output rounding.
`default_nettype none
module imucf_chain
    import imucf_pkg::*;
#(
    parameter int CORDIC_STEPS    = CordicStepsDef,
    parameter int ANGLE_FRAC_BITS = AngleFracDef
) (
    input  wire                 i_clk,
    input  wire signed [15:0]   i_y,
    input  wire signed [15:0]   i_x,
    output logic signed [31:0]  o_angle
);
    localparam int N = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int SH = 24 - ANGLE_FRAC_BITS;

    t_vec v [0:N];
    logic signed [XW-1:0] xe, ye;
    logic signed [ZW-1:0] zr;

    always_comb begin
        xe = XW'(i_x) <<< 24;
        ye = XW'(i_y) <<< 24;
        v[0].x = xe;
        v[0].y = ye;
        v[0].z = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                v[0].x = ye;
                v[0].y = -xe;
                v[0].z = ZW'(90) <<< 24;
            end else begin
                v[0].x = -ye;
                v[0].y = xe;
                v[0].z = -(ZW'(90) <<< 24);
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        imucf_cell #(.STEP(g)) u_cell (.i_clk(i_clk), .i_vec(v[g]), .o_vec(v[g+1]));
    end

    // zero vector gives angle 0; inputs are held steady while the row works
    always_comb begin
        zr = (v[N].z + (ZW'(1) <<< (SH - 1))) >>> SH;
        o_angle = (i_x == 16'sd0 && i_y == 16'sd0) ? 32'sd0 : 32'(zr);
    end
endmodule
`default_nettype wire

// File: hw/rtl/imu_complementary_filter_top.sv
// Top level: IMU complementary attitude filter with APB configuration.
`default_nettype none
// One word in gives one word out. Each of the three accelerometer angles runs
// through a row of registered cells (one micro-rotation each, CORDIC_STEPS of
// them, capped at the arctangent table length), all three rows in parallel.
// The result word is registered behind the cell row and one blend product
// stage, with the sequencer count padded so the gyro product and integration
// stages are long settled. One item is in work at a time; the result sits in
// an output register and ready rises the cycle after that result is taken, so
// a new word is taken only once the previous result has been taken. atan2(0,0)
// yields 0. The stored angles saturate at the signed 32-bit limits.
module imu_complementary_filter_top
    import imucf_pkg::*;
#(
    parameter int CORDIC_STEPS    = CordicStepsDef,
    parameter int ANGLE_FRAC_BITS = AngleFracDef
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [3:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire signed [15:0]  i_accel_x,
    input  wire signed [15:0]  i_accel_y,
    input  wire signed [15:0]  i_accel_z,
    input  wire signed [15:0]  i_gyro_x,
    input  wire signed [15:0]  i_gyro_y,
    input  wire signed [15:0]  i_gyro_z,
    output logic               o_valid,
    input  wire                i_ready,
    output logic signed [31:0] o_pitch_angle,
    output logic signed [31:0] o_roll_angle,
    output logic signed [31:0] o_yaw_angle,
    output logic               o_blended
);
    localparam int N = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int GS = 32 - ANGLE_FRAC_BITS;
    localparam int LAT = N + 2;  // CORDIC row depth plus margin for the sequencer count
    localparam int CW = $clog2(LAT + 4);
    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StRun  = 2'd1;
    localparam logic [1:0] StOut  = 2'd2;

    // configuration registers
    logic [23:0] r_gain;
    logic [15:0] r_alpha;
    logic [16:0] r_mlow, r_mhigh;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= 24'd327861;
            r_alpha <= 16'd32113;
            r_mlow  <= 17'd8192;
            r_mhigh <= 17'd32768;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                AddrGain[1:0]:  r_gain  <= pwdata[23:0];
                AddrAlpha[1:0]: r_alpha <= pwdata[15:0];
                AddrMlow[1:0]:  r_mlow  <= pwdata[16:0];
                AddrMhigh[1:0]: r_mhigh <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            AddrGain[1:0]:  prdata = {8'd0, r_gain};
            AddrAlpha[1:0]: prdata = {16'd0, r_alpha};
            AddrMlow[1:0]:  prdata = {15'd0, r_mlow};
            AddrMhigh[1:0]: prdata = {15'd0, r_mhigh};
            default:        prdata = '0;
        endcase
    end

    // sequencer
    logic [1:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy, r_gz;
    logic signed [31:0] r_pitch, r_roll, r_yaw;
    logic signed [41:0] r_dp, r_dr, r_dy;
    logic signed [31:0] r_ip, r_ir, r_iy;  // integrated angles
    logic r_blend;
    logic signed [31:0] acc_p, acc_r, acc_y;
    logic signed [49:0] r_bp, r_br, r_by;

    wire accept = i_valid && o_ready;
    assign o_ready = (r_state == StIdle);
    assign o_valid = (r_state == StOut);

    imucf_chain #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
        u_cp (.i_clk(i_clk), .i_y(r_ay), .i_x(r_az), .o_angle(acc_p));
    imucf_chain #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
        u_cr (.i_clk(i_clk), .i_y(r_ax), .i_x(r_az), .o_angle(acc_r));
    imucf_chain #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
        u_cy (.i_clk(i_clk), .i_y(r_az), .i_x(r_ax), .o_angle(acc_y));

    function automatic logic signed [31:0] sat(input logic signed [49:0] v);
        if (v > 50'sh7FFFFFFF) sat = 32'sh7FFFFFFF;
        else if (v < -50'sh80000000) sat = 32'sh80000000;
        else sat = 32'(v);
    endfunction

    function automatic logic [16:0] absv(input logic signed [15:0] v);
        absv = v[15] ? 17'(-(17'(v))) : 17'(v);
    endfunction

    logic [17:0] mag;
    logic        win;
    logic [15:0] a;
    logic signed [49:0] rnd_p, rnd_r, rnd_y;
    assign mag = 18'(absv(r_ax)) + 18'(absv(r_ay)) + 18'(absv(r_az));
    assign win = (mag > 18'(r_mlow)) && (mag < 18'(r_mhigh));
    assign a = (r_alpha > 16'd32768) ? 16'd32768 : r_alpha;
    assign rnd_p = (50'(r_dp) + (50'sd1 <<< (GS - 1))) >>> GS;
    assign rnd_r = (50'(r_dr) + (50'sd1 <<< (GS - 1))) >>> GS;
    assign rnd_y = (50'(r_dy) + (50'sd1 <<< (GS - 1))) >>> GS;

    logic signed [17:0] as, bs;
    assign as = 18'(a);
    assign bs = 18'sd32768 - as;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_cnt   <= '0;
            r_pitch <= '0;
            r_roll  <= '0;
            r_yaw   <= '0;
            r_blend <= 1'b0;
        end else begin
            case (r_state)
                StIdle: if (accept) begin
                    r_state <= StRun;
                    r_cnt   <= '0;
                end
                StRun: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(LAT + 2)) begin
                        r_state <= StOut;
                        r_blend <= win;
                        if (win) begin
                            r_pitch <= sat((r_bp + 50'sd16384) >>> 15);
                            r_roll  <= sat((r_br + 50'sd16384) >>> 15);
                            r_yaw   <= sat((r_by + 50'sd16384) >>> 15);
                        end else begin
                            r_pitch <= r_ip;
                            r_roll  <= r_ir;
                            r_yaw   <= r_iy;
                        end
                    end
                end
                StOut: if (i_ready) r_state <= StIdle;
                default: r_state <= StIdle;
            endcase
        end
    end

    // datapath: gyro products, integration, blend products
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ax <= i_accel_x; r_ay <= i_accel_y; r_az <= i_accel_z;
            r_gx <= i_gyro_x;  r_gy <= i_gyro_y;  r_gz <= i_gyro_z;
        end
        r_dp <= 42'(r_gx) * $signed({1'b0, r_gain});
        r_dr <= 42'(r_gy) * $signed({1'b0, r_gain});
        r_dy <= 42'(r_gz) * $signed({1'b0, r_gain});
        r_ip <= sat(50'(r_pitch) + rnd_p);
        r_ir <= sat(50'(r_roll) - rnd_r);
        r_iy <= sat(50'(r_yaw) + rnd_y);
        r_bp <= 50'(as) * 50'(r_ip) + 50'(bs) * 50'(acc_p);
        r_br <= 50'(as) * 50'(r_ir) + 50'(bs) * 50'(acc_r);
        r_by <= 50'(as) * 50'(r_iy) + 50'(bs) * 50'(acc_y);
    end

    assign o_pitch_angle = r_pitch;
    assign o_roll_angle  = r_roll;
    assign o_yaw_angle   = r_yaw;
    assign o_blended     = r_blend;

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_pitch_angle) && $stable(o_blended))
        else $error("result changed while stalled");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready) else $error("accepted twice");
endmodule
`default_nettype wire

// File: dv/imu_complementary_filter_top_tb.sv
// Testbench: IMU complementary filter top, checked word by word against a predictor.
`timescale 1ns / 1ps
module imu_complementary_filter_top_tb;
    import imucf_pkg::*;

    // Register indexes, matching the byte map (index * 4).
    typedef enum logic [1:0] {
        REG_GAIN  = 2'd0,
        REG_ALPHA = 2'd1,
        REG_MLOW  = 2'd2,
        REG_MHIGH = 2'd3
    } t_reg;

    localparam int FracBits     = AngleFracDef;
    localparam int CordicSteps  = CordicStepsDef;
    localparam int DrainCycles  = 40;    // extra wait after the expected-result queue empties
    localparam int StallLimit   = 3000;  // cycles with no word moving on either side
    localparam int RandomPhases = 8;
    localparam int PhaseItems   = 142;

    typedef struct packed {
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
        logic signed [31:0] yaw;
        logic               blended;
    } t_attitude;

    typedef struct packed {
        logic signed [15:0] ax, ay, az, gx, gy, gz;
    } t_imu;

    typedef struct packed {
        t_imu      imu;
        logic      typed;   // expected word written into the row
        t_attitude att;
    } t_row;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic i_valid, o_ready, o_valid, i_ready;
    logic signed [15:0] i_accel_x, i_accel_y, i_accel_z, i_gyro_x, i_gyro_y, i_gyro_z;
    logic signed [31:0] o_pitch_angle, o_roll_angle, o_yaw_angle;
    logic o_blended;

    imu_complementary_filter_top u_top (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_valid, .o_ready, .i_accel_x, .i_accel_y, .i_accel_z,
        .i_gyro_x, .i_gyro_y, .i_gyro_z, .o_valid, .i_ready,
        .o_pitch_angle, .o_roll_angle, .o_yaw_angle, .o_blended
    );

    // Predictor state: a private copy of the registers and the three angles.
    logic [23:0] cfg_gain;
    logic [15:0] cfg_alpha;
    logic [16:0] cfg_mlow, cfg_mhigh;
    logic signed [31:0] pitch_acc, roll_acc, yaw_acc;

    t_attitude attitude_q[$];
    int  n_errors = 0;
    bit  no_idle;       // set during the stretch with no gaps on either side
    int  quiet_cycles = 0;

    // atan(2^-i), 2^-24 degree
    longint atan_step [24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Vectoring CORDIC: atan2(y, x) in degrees with FracBits fraction bits.
    function automatic longint atan2_deg(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x <<< 24;
        y = y <<< 24;
        if (x < 0) begin
            // fold the left half plane in with a quarter turn
            t = x;
            if (y >= 0) begin
                x = y;  y = -t; z = 90 <<< 24;
            end else begin
                x = -y; y = t;  z = -(90 <<< 24);
            end
        end
        for (int i = 0; i < CordicSteps && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + atan_step[i];
            end else begin
                x = x - ys; y = y + xs; z = z - atan_step[i];
            end
        end
        return (z + (64'sd1 <<< (24 - FracBits - 1))) >>> (24 - FracBits);
    endfunction

    function automatic longint gyro_step(longint g);
        longint p;
        p = g * longint'(cfg_gain);
        return (p + (64'sd1 <<< (32 - FracBits - 1))) >>> (32 - FracBits);
    endfunction

    function automatic longint mix(longint angle, longint acc, longint a);
        return clamp32((a * angle + (32768 - a) * acc + 16384) >>> 15);
    endfunction

    // Advances the predictor by one IMU word and returns the attitude it gives.
    function automatic t_attitude predict_attitude(t_imu s);
        t_attitude r;
        longint ax, ay, az, mag, a;
        ax = s.ax; ay = s.ay; az = s.az;
        pitch_acc = 32'(clamp32(longint'(pitch_acc) + gyro_step(s.gx)));
        roll_acc  = 32'(clamp32(longint'(roll_acc)  - gyro_step(s.gy)));
        yaw_acc   = 32'(clamp32(longint'(yaw_acc)   + gyro_step(s.gz)));
        mag = (ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay) + (az < 0 ? -az : az);
        r.blended = (mag > longint'(cfg_mlow)) && (mag < longint'(cfg_mhigh));
        if (r.blended) begin
            a = (cfg_alpha > 16'd32768) ? 32768 : longint'(cfg_alpha);
            pitch_acc = 32'(mix(pitch_acc, atan2_deg(ay, az), a));
            roll_acc  = 32'(mix(roll_acc,  atan2_deg(ax, az), a));
            yaw_acc   = 32'(mix(yaw_acc,   atan2_deg(az, ax), a));
        end
        r.pitch = pitch_acc;
        r.roll  = roll_acc;
        r.yaw   = yaw_acc;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint want, longint got);
        $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
        n_errors++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 16);
    endfunction

    // Result side: ready toggles at random at the falling edge.
    always @(negedge i_clk) begin
        i_ready <= !idle_now();
    end

    // Result check and stall watchdog, both at the rising edge.
    always @(posedge i_clk) begin
        t_attitude want;
        if (i_rst_n && o_valid && i_ready) begin
            if (attitude_q.size() == 0) begin
                $display("unexpected result word at %0t", $realtime);
                n_errors++;
            end else begin
                want = attitude_q.pop_front();
                if (o_pitch_angle !== want.pitch)
                    report_mismatch("pitch", want.pitch, o_pitch_angle);
                if (o_roll_angle !== want.roll)
                    report_mismatch("roll", want.roll, o_roll_angle);
                if (o_yaw_angle !== want.yaw)
                    report_mismatch("yaw", want.yaw, o_yaw_angle);
                if (o_blended !== want.blended)
                    report_mismatch("blended", want.blended, o_blended);
            end
        end
        if ((o_valid && i_ready) || (i_valid && o_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // Two-phase APB write; the register lands at the access-phase rising edge.
    task automatic apb_write(t_reg idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GAIN:  cfg_gain  = value[23:0];
            REG_ALPHA: cfg_alpha = value[15:0];
            REG_MLOW:  cfg_mlow  = value[16:0];
            REG_MHIGH: cfg_mhigh = value[16:0];
            default: ;
        endcase
    endtask

    // Sends one word; valid stays up across back-to-back words. The predictor runs
    // at the accepting edge; its result, or the typed-in value from the table, is queued.
    task automatic send_imu(t_imu s, bit typed, t_attitude att);
        t_attitude p;
        @(negedge i_clk);
        while (idle_now()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_accel_x <= s.ax;
        i_accel_y <= s.ay;
        i_accel_z <= s.az;
        i_gyro_x  <= s.gx;
        i_gyro_y  <= s.gy;
        i_gyro_z  <= s.gz;
        do @(posedge i_clk); while (!o_ready);
        p = predict_attitude(s);
        attitude_q.push_back(typed ? att : p);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (attitude_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // Random IMU word: mostly inside a plausible gravity window so the blend and
    // every CORDIC quadrant get exercised, the rest full-scale noise and corners.
    function automatic t_imu random_imu();
        t_imu s;
        int pick, span;
        pick = $urandom_range(99);
        s = '0;
        s.gx = 16'($urandom());
        s.gy = 16'($urandom());
        s.gz = 16'($urandom());
        if (pick < 60) begin
            span = $urandom_range(1, 3) * 6000;
            s.ax = 16'($urandom_range(2 * span) - span);
            s.ay = 16'($urandom_range(2 * span) - span);
            s.az = 16'($urandom_range(2 * span) - span);
            if ($urandom_range(3) == 0) begin
                s.gx = 16'($urandom_range(2000) - 1000);
                s.gy = 16'($urandom_range(2000) - 1000);
                s.gz = 16'($urandom_range(2000) - 1000);
            end
        end else if (pick < 85) begin
            s.ax = 16'($urandom());
            s.ay = 16'($urandom());
            s.az = 16'($urandom());
        end else begin
            s.ax = ($urandom_range(2) == 0) ? 16'sh8000
                 : ($urandom_range(1) ? 16'sh7FFF : 16'sh0000);
            s.ay = ($urandom_range(2) == 0) ? 16'sh8000
                 : ($urandom_range(1) ? 16'sh7FFF : 16'sh0000);
            s.az = ($urandom_range(2) == 0) ? 16'sh8000
                 : ($urandom_range(1) ? 16'sh7FFF : 16'sh0000);
        end
        return s;
    endfunction

    // Directed rows, default registers. Angles start at zero, so the first rows
    // (no gyro, magnitude outside the window) read off as zero.
    localparam t_attitude Z = '0;
    t_row dir_rows [16] = '{
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, Z},
        '{'{-16'sd32768, -16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 16'sd0}, 1'b1, Z},
        '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0, 16'sd0}, 1'b1, Z},
        // magnitude exactly on the lower and upper window edges: no blend
        '{'{16'sd8192, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, Z},
        '{'{16'sd0, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, Z},
        // gyro extremes
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd32767}, 1'b0, Z},
        '{'{16'sd0, 16'sd0, 16'sd0, -16'sd32768, 16'sd32767, -16'sd32768}, 1'b0, Z},
        // just inside the window
        '{'{16'sd8193, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, Z},
        '{'{16'sd0, 16'sd0, -16'sd32767, 16'sd5, 16'sd5, 16'sd5}, 1'b0, Z},
        // yaw sees the zero vector (az = ax = 0)
        '{'{16'sd0, 16'sd16384, 16'sd0, 16'sd100, -16'sd100, 16'sd0}, 1'b0, Z},
        // CORDIC quadrant folds (x < 0 with y >= 0 and y < 0), plus rows with no fold
        '{'{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b0, Z},
        '{'{-16'sd9000, -16'sd9000, -16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b0, Z},
        '{'{16'sd10000, -16'sd10000, 16'sd5000, -16'sd300, 16'sd300, 16'sd7}, 1'b0, Z},
        '{'{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, Z},
        '{'{16'sd12000, 16'sd12000, -16'sd8000, 16'sd1, -16'sd1, -16'sd1}, 1'b0, Z},
        '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b0, Z}
    };

    initial begin
        logic [31:0] gain, alpha, lo, hi;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_valid = 1'b0;
        {i_accel_x, i_accel_y, i_accel_z, i_gyro_x, i_gyro_y, i_gyro_z} = '0;
        no_idle = 1'b0;
        cfg_gain = 24'd327861; cfg_alpha = 16'd32113;
        cfg_mlow = 17'd8192;   cfg_mhigh = 17'd32768;
        pitch_acc = '0; roll_acc = '0; yaw_acc = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part under the reset register values.
        foreach (dir_rows[r])
            send_imu(dir_rows[r].imu, dir_rows[r].typed, dir_rows[r].att);
        drain();

        // Random phases; each starts idle with a fresh set of all four registers.
        for (int ph = 0; ph < RandomPhases; ph++) begin
            case (ph)
                0: begin
                    gain = 32'hFFFFFF; alpha = 32'd32768; lo = 32'd0; hi = 32'd98304;
                end
                1: begin
                    gain = 32'd0; alpha = 32'd0; lo = 32'd8192; hi = 32'd32768;
                end
                2: begin
                    gain = $urandom(); alpha = 32'hFFFF; lo = 32'd100; hi = 32'h1FFFF;
                end
                3: begin
                    gain = $urandom(); alpha = $urandom(); lo = 32'd40000; hi = 32'd20000;
                end
                4: begin
                    gain = 32'hFFFFFF; alpha = 32'd0; lo = 32'd1000; hi = 32'd60000;
                end
                default: begin
                    gain  = $urandom_range(24'hFFFFFF);
                    alpha = $urandom_range(32768);
                    lo    = $urandom_range(20000);
                    hi    = lo + $urandom_range(1, 60000);
                end
            endcase
            apb_write(REG_GAIN, gain);
            apb_write(REG_ALPHA, alpha);
            apb_write(REG_MLOW, lo);
            apb_write(REG_MHIGH, hi);
            no_idle = (ph == 5);  // one phase runs back to back on both sides
            for (int n = 0; n < PhaseItems; n++)
                send_imu(random_imu(), 1'b0, Z);
            drain();
            no_idle = 1'b0;
        end

        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
